/* src/pbc_pkg.sv */
package pbc_pkg;

  localparam int W         = 24;
  localparam int F         = 20;
  localparam int XW        = 58;
  localparam int MW        = 28;
  localparam int PW        = 2 * MW;
  localparam int DNB       = 51;
  localparam int DENW      = 23;
  localparam int SW        = 27;
  localparam int ROOT_BITS = 23;
  localparam int SQ_BITS   = 2 * ROOT_BITS;
  localparam int CNTW      = 6;

  localparam logic [2:0] REG_HALF_BOX    = 3'd0;
  localparam logic [2:0] REG_BALL_RADIUS = 3'd1;
  localparam logic [2:0] REG_TIME_STEP   = 3'd2;
  localparam logic [2:0] REG_MASS_P      = 3'd3;
  localparam logic [2:0] REG_MASS_B      = 3'd4;

  typedef logic signed [W-1:0]  word_t;
  typedef logic signed [XW-1:0] wide_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  localparam wide_t SMAX = wide_t'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam wide_t SMIN = -SMAX - wide_t'(1);

  function automatic word_t sat(input wide_t x);
    word_t r;
    if (x > SMAX) begin
      r = word_t'(SMAX);
    end else if (x < SMIN) begin
      r = word_t'(SMIN);
    end else begin
      r = word_t'(x);
    end
    return r;
  endfunction

endpackage

/* src/pbc_divsqrt.sv */
module pbc_divsqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  pbc_pkg::div_req_t      req,
  input  pbc_pkg::wide_t         num,
  input  logic [pbc_pkg::DENW-1:0] den,
  output pbc_pkg::div_rsp_t      rsp,
  output pbc_pkg::wide_t         res
);
  import pbc_pkg::*;

  logic [DNB-1:0]  acc;
  logic [DNB-1:0]  quo;
  logic [SW-1:0]   rem;
  logic [DENW-1:0] dvr;
  logic [CNTW-1:0] cnt;
  logic            run;
  logic            mode;
  logic            neg;
  logic            done;

  logic [SW-1:0] op_a;
  logic [SW-1:0] op_b;
  logic [SW-1:0] diff;
  logic          ge;
  wide_t         mag;
  wide_t         num_abs;

  always_comb begin
    if (mode) begin
      op_a = {rem[SW-3:0], acc[DNB-1:DNB-2]};
      op_b = {quo[SW-3:0], 2'b01};
    end else begin
      op_a = {rem[SW-2:0], acc[DNB-1]};
      op_b = SW'(dvr);
    end
    ge      = (op_a >= op_b);
    diff    = op_a - op_b;
    num_abs = num[XW-1] ? -num : num;
    mag     = wide_t'({{(XW-DNB){1'b0}}, quo});
    res     = neg ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        run  <= 1'b1;
        done <= 1'b0;
        mode <= req.sqrt_mode;
        dvr  <= den;
        rem  <= '0;
        quo  <= '0;
        if (req.sqrt_mode) begin
          acc <= {num[SQ_BITS-1:0], {(DNB-SQ_BITS){1'b0}}};
          cnt <= CNTW'(ROOT_BITS - 1);
          neg <= 1'b0;
        end else begin
          acc <= num_abs[DNB-1:0];
          cnt <= CNTW'(DNB - 1);
          neg <= num[XW-1];
        end
      end else if (run) begin
        rem  <= ge ? diff : op_a;
        quo  <= {quo[DNB-2:0], ge};
        acc  <= mode ? {acc[DNB-3:0], 2'b00} : {acc[DNB-2:0], 1'b0};
        cnt  <= cnt - CNTW'(1);
        done <= (cnt == '0);
        if (cnt == '0) begin
          run <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.busy = run;
  assign rsp.done = done;

endmodule

/* src/particle_ball_box_collision_step.sv */
// Q3.20 step of one stored ball in a square box, struck by point particles. kind 0 moves
// the ball one time step and mirrors it off the walls; kind 1 moves the given particle,
// mirrors it off the walls and, on overlap, pushes it out of the ball and exchanges an
// elastic normal impulse, updating the stored ball velocity. One word is in flight at a
// time. It is computed with one shared bit-serial divide/square-root unit (one square
// root of 23 steps and nine divisions of 51 steps, one quotient bit a cycle), used only
// on a hit, and one shared multiplier registered at its output. A finished word waits in
// the output register while the next one runs; if it is still waiting when the next is
// finished, the block holds until it is taken.
module particle_ball_box_collision_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [22:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic signed [23:0]    in_pos_x,
  input  logic signed [23:0]    in_pos_y,
  input  logic signed [23:0]    in_vel_x,
  input  logic signed [23:0]    in_vel_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [23:0]    out_pos_x,
  output logic signed [23:0]    out_pos_y,
  output logic signed [23:0]    out_vel_x,
  output logic signed [23:0]    out_vel_y,
  output logic                  hit_wall,
  output logic                  hit_ball
);
  import pbc_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0,  S_AX  = 6'd1,  S_AY  = 6'd2,  S_AD  = 6'd3;
  localparam logic [5:0] S_W0   = 6'd4,  S_W1  = 6'd5,  S_W2  = 6'd6,  S_W3  = 6'd7;
  localparam logic [5:0] S_DX   = 6'd8,  S_SQ1 = 6'd9,  S_SQ2 = 6'd10, S_SQ3 = 6'd11;
  localparam logic [5:0] S_CMP  = 6'd12, S_SQR = 6'd13, S_SQW = 6'd14, S_P1  = 6'd15;
  localparam logic [5:0] S_P2   = 6'd16, S_P2W = 6'd17, S_P3  = 6'd18, S_P4  = 6'd19;
  localparam logic [5:0] S_P4W  = 6'd20, S_D1  = 6'd21, S_D2  = 6'd22, S_D3  = 6'd23;
  localparam logic [5:0] S_D3W  = 6'd24, S_N1  = 6'd25, S_N2  = 6'd26, S_N2W = 6'd27;
  localparam logic [5:0] S_N3   = 6'd28, S_N4  = 6'd29, S_N4W = 6'd30, S_I1  = 6'd31;
  localparam logic [5:0] S_I2   = 6'd32, S_I2W = 6'd33, S_I3  = 6'd34, S_I4  = 6'd35;
  localparam logic [5:0] S_I4W  = 6'd36, S_I5  = 6'd37, S_I6  = 6'd38, S_I6W = 6'd39;
  localparam logic [5:0] S_I7   = 6'd40, S_I8  = 6'd41, S_I8W = 6'd42, S_OUT = 6'd43;

  logic [5:0] state;
  logic [5:0] state_next;

  logic [22:0] half_box;
  logic [22:0] ball_radius;
  logic [20:0] time_step;
  logic [15:0] mass_p;
  logic [15:0] mass_b;

  word_t ball_pos_x, ball_pos_y, ball_vel_x, ball_vel_y;
  word_t px, py, vx, vy;
  logic  is_particle;
  logic  hw, hb;
  logic [22:0] rad;
  logic signed [24:0] dx, dy;
  logic [DENW-1:0] dlen;
  wide_t t0, t1, nx, ny;
  logic signed [PW-1:0] preg;

  logic signed [MW-1:0] mul_a, mul_b;
  div_req_t div_req;
  div_rsp_t div_rsp;
  wide_t    div_num;
  logic [DENW-1:0] div_den;
  wide_t    div_res;

  logic [16:0] msum;
  logic [16:0] wp2, wb2;
  logic [DENW-1:0] msum_d;
  logic [24:0] push;
  logic signed [PW-F-1:0] step_q;
  wide_t preg_w;

  logic [1:0] wk;
  word_t wp_sel, wv_sel, wp_new, wv_new;
  logic signed [26:0] wh;
  logic  whit;

  pbc_divsqrt u_divsqrt (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .num (div_num),
    .den (div_den),
    .rsp (div_rsp),
    .res (div_res)
  );

  assign cfg_ready = (state == S_IDLE) && !in_valid;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    msum = {1'b0, mass_b} + {1'b0, mass_p};
    if (msum == '0) begin
      wp2  = 17'd2;
      wb2  = 17'd2;
      msum = 17'd2;
    end else begin
      wp2 = {mass_b, 1'b0};
      wb2 = {mass_p, 1'b0};
    end
    msum_d = DENW'(msum);
    push   = {ball_radius - dlen, 1'b0};
    preg_w = wide_t'(preg);
    step_q = (PW-F)'((preg + (preg < 0 ? PW'((64'sd1 <<< F) - 64'sd1) : PW'(0))) >>> F);
  end

  always_comb begin
    wk     = 2'(state - S_W0);
    wp_sel = wk[0] ? py : px;
    wv_sel = wk[0] ? vy : vx;
    if (wk[1]) begin
      wh = 27'($signed({1'b0, half_box})) - 27'(wp_sel) - 27'($signed({1'b0, rad}));
    end else begin
      wh = 27'(wp_sel) + 27'($signed({1'b0, half_box})) - 27'($signed({1'b0, rad}));
    end
    whit = (wh <= 0);
    if (wk[1]) begin
      wp_new = sat(wide_t'(wp_sel) + (wide_t'(wh) <<< 1));
    end else begin
      wp_new = sat(wide_t'(wp_sel) - (wide_t'(wh) <<< 1));
    end
    wv_new = sat(-wide_t'(wv_sel));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_AX: begin
        mul_a = MW'(vx);
        mul_b = MW'($signed({1'b0, time_step}));
      end
      S_AY: begin
        mul_a = MW'(vy);
        mul_b = MW'($signed({1'b0, time_step}));
      end
      S_SQ1: begin
        mul_a = MW'(dx);
        mul_b = MW'(dx);
      end
      S_SQ2: begin
        mul_a = MW'(dy);
        mul_b = MW'(dy);
      end
      S_SQ3: begin
        mul_a = MW'($signed({1'b0, ball_radius}));
        mul_b = MW'($signed({1'b0, ball_radius}));
      end
      S_P1: begin
        mul_a = MW'($signed({1'b0, push}));
        mul_b = MW'(dx);
      end
      S_P3: begin
        mul_a = MW'($signed({1'b0, push}));
        mul_b = MW'(dy);
      end
      S_D1: begin
        mul_a = MW'(25'(vx) - 25'(ball_vel_x));
        mul_b = MW'(dx);
      end
      S_D2: begin
        mul_a = MW'(25'(vy) - 25'(ball_vel_y));
        mul_b = MW'(dy);
      end
      S_N1: begin
        mul_a = MW'(t0);
        mul_b = MW'(dx);
      end
      S_N3: begin
        mul_a = MW'(t0);
        mul_b = MW'(dy);
      end
      S_I1: begin
        mul_a = MW'(nx);
        mul_b = MW'($signed({1'b0, wp2}));
      end
      S_I3: begin
        mul_a = MW'(ny);
        mul_b = MW'($signed({1'b0, wp2}));
      end
      S_I5: begin
        mul_a = MW'(nx);
        mul_b = MW'($signed({1'b0, wb2}));
      end
      S_I7: begin
        mul_a = MW'(ny);
        mul_b = MW'($signed({1'b0, wb2}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start     = 1'b0;
    div_req.sqrt_mode = 1'b0;
    div_num           = preg_w;
    div_den           = dlen;
    case (state)
      S_SQR: begin
        div_req.start     = 1'b1;
        div_req.sqrt_mode = 1'b1;
        div_num           = t0;
      end
      S_P2, S_P4, S_N2, S_N4: begin
        div_req.start = 1'b1;
      end
      S_D3: begin
        div_req.start = 1'b1;
        div_num       = t0 + preg_w;
      end
      S_I2, S_I4, S_I6, S_I8: begin
        div_req.start = 1'b1;
        div_den       = msum_d;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_AX;
      S_AX, S_AY, S_AD, S_W0, S_W1, S_W2: state_next = state + 6'd1;
      S_W3: state_next = is_particle ? S_DX : S_OUT;
      S_DX, S_SQ1, S_SQ2, S_SQ3: state_next = state + 6'd1;
      S_CMP: begin
        if (t0 == '0 || t0 > preg_w) begin
          state_next = S_OUT;
        end else begin
          state_next = S_SQR;
        end
      end
      S_SQW, S_P2W, S_P4W, S_D3W, S_N2W, S_N4W, S_I2W, S_I4W, S_I6W, S_I8W: begin
        if (div_rsp.done) state_next = state + 6'd1;
      end
      S_OUT: if (!out_valid || out_ready) state_next = S_IDLE;
      default: begin
        if (state > S_OUT) begin
          state_next = S_IDLE;
        end else begin
          state_next = state + 6'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      half_box    <= 23'd786432;
      ball_radius <= 23'd314573;
      time_step   <= 21'd10486;
      mass_p      <= 16'd256;
      mass_b      <= 16'd2560;
      ball_pos_x  <= '0;
      ball_pos_y  <= '0;
      ball_vel_x  <= '0;
      ball_vel_y  <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HALF_BOX:    half_box    <= cfg_data;
          REG_BALL_RADIUS: ball_radius <= cfg_data;
          REG_TIME_STEP:   time_step   <= cfg_data[20:0];
          REG_MASS_P:      mass_p      <= cfg_data[15:0];
          REG_MASS_B:      mass_b      <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_W3: if (!is_particle) begin
          ball_pos_x <= px;
          ball_pos_y <= whit ? wp_new : py;
          ball_vel_x <= vx;
          ball_vel_y <= whit ? wv_new : vy;
        end
        S_I6W: if (div_rsp.done) ball_vel_x <= sat(wide_t'(ball_vel_x) + div_res);
        S_I8W: if (div_rsp.done) ball_vel_y <= sat(wide_t'(ball_vel_y) + div_res);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    preg <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          is_particle <= kind;
          hw          <= 1'b0;
          hb          <= 1'b0;
          if (kind) begin
            px  <= in_pos_x;
            py  <= in_pos_y;
            vx  <= in_vel_x;
            vy  <= in_vel_y;
            rad <= '0;
          end else begin
            px  <= ball_pos_x;
            py  <= ball_pos_y;
            vx  <= ball_vel_x;
            vy  <= ball_vel_y;
            rad <= ball_radius;
          end
        end
      end
      S_AY: px <= sat(wide_t'(px) + wide_t'(step_q));
      S_AD: py <= sat(wide_t'(py) + wide_t'(step_q));
      S_W0, S_W1, S_W2, S_W3: begin
        if (whit) begin
          hw <= 1'b1;
          if (wk[0]) begin
            py <= wp_new;
            vy <= wv_new;
          end else begin
            px <= wp_new;
            vx <= wv_new;
          end
        end
      end
      S_DX: begin
        dx <= 25'(px) - 25'(ball_pos_x);
        dy <= 25'(py) - 25'(ball_pos_y);
      end
      S_SQ2: t0 <= preg_w;
      S_SQ3: t0 <= t0 + preg_w;
      S_SQW: if (div_rsp.done) dlen <= div_res[DENW-1:0];
      S_P2W: if (div_rsp.done) t1 <= div_res;
      S_P4W: begin
        if (div_rsp.done) begin
          px <= sat(wide_t'(px) + t1);
          py <= sat(wide_t'(py) + div_res);
        end
      end
      S_D2: t0 <= preg_w;
      S_D3W: if (div_rsp.done) t0 <= div_res;
      S_N2W: if (div_rsp.done) nx <= div_res;
      S_N4W: if (div_rsp.done) ny <= div_res;
      S_I2W: if (div_rsp.done) vx <= sat(wide_t'(vx) - div_res);
      S_I4W: begin
        if (div_rsp.done) begin
          vy <= sat(wide_t'(vy) - div_res);
          hb <= 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_pos_x <= px;
          out_pos_y <= py;
          out_vel_x <= vx;
          out_vel_y <= vy;
          hit_wall  <= hw;
          hit_ball  <= hb;
        end
      end
      default: ;
    endcase
  end

  a_idle_unit_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_rsp.busy)
    else $error("shared unit busy while idle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_SQW || state == S_P2W || state == S_P4W ||
                      state == S_D3W || state == S_N2W || state == S_N4W ||
                      state == S_I2W || state == S_I4W || state == S_I6W ||
                      state == S_I8W))
    else $error("unit finished outside a wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_AX))
    else $error("accepted word did not start");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import pbc_pkg::*;

  typedef struct {
    logic  kind;
    word_t px, py, vx, vy;
  } stim_t;

  typedef struct {
    word_t px, py, vx, vy;
    logic  hw, hb;
  } state_word_t;

  typedef struct {
    stim_t       st;
    bit          typed;
    state_word_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [22:0] cfg_data;
  logic in_valid, in_ready, kind;
  logic signed [23:0] in_pos_x, in_pos_y, in_vel_x, in_vel_y;
  logic out_valid, out_ready;
  logic signed [23:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
  logic hit_wall, hit_ball;

  particle_ball_box_collision_step u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model copy of registers and ball
  longint m_half, m_rad, m_ts, m_pmass, m_bmass;
  longint b_px, b_py, b_vx, b_vy;
  state_word_t pending[$];
  int fails = 0;
  bit calm = 1'b0;

  localparam longint WMAXL = (64'sd1 <<< 23) - 1;
  localparam longint WMINL = -WMAXL - 1;
  localparam int SETTLE = 700;

  function automatic longint clamp_word(longint x);
    if (x > WMAXL) return WMAXL;
    if (x < WMINL) return WMINL;
    return x;
  endfunction

  function automatic longint root_floor(longint v);
    logic [63:0] x, r, b;
    x = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  task automatic move(inout longint p, input longint v);
    p = clamp_word(p + (v * m_ts) / 1048576);
  endtask

  task automatic bounce(inout longint px, inout longint py, inout longint vx,
                        inout longint vy, input longint rad, output logic hit);
    longint h;
    hit = 1'b0;
    h = px + m_half - rad;
    if (h <= 0) begin
      px = clamp_word(px - 2 * h); vx = clamp_word(-vx); hit = 1'b1;
    end
    h = py + m_half - rad;
    if (h <= 0) begin
      py = clamp_word(py - 2 * h); vy = clamp_word(-vy); hit = 1'b1;
    end
    h = m_half - px - rad;
    if (h <= 0) begin
      px = clamp_word(px + 2 * h); vx = clamp_word(-vx); hit = 1'b1;
    end
    h = m_half - py - rad;
    if (h <= 0) begin
      py = clamp_word(py + 2 * h); vy = clamp_word(-vy); hit = 1'b1;
    end
  endtask

  task automatic step_collision(input stim_t s, output state_word_t r);
    longint px, py, vx, vy, dx, dy, d2, dlen, push, dot, vn, nx, ny, wp, wb, tot;
    logic hw, hb;
    hb = 1'b0;
    if (s.kind == 1'b0) begin
      move(b_px, b_vx);
      move(b_py, b_vy);
      bounce(b_px, b_py, b_vx, b_vy, m_rad, hw);
      px = b_px; py = b_py; vx = b_vx; vy = b_vy;
    end else begin
      px = s.px; py = s.py; vx = s.vx; vy = s.vy;
      move(px, vx);
      move(py, vy);
      bounce(px, py, vx, vy, 0, hw);
      dx = px - b_px;
      dy = py - b_py;
      d2 = dx * dx + dy * dy;
      if (d2 != 0 && d2 <= m_rad * m_rad) begin
        hb = 1'b1;
        dlen = root_floor(d2);
        push = 2 * (m_rad - dlen);
        px = clamp_word(px + (push * dx) / dlen);
        py = clamp_word(py + (push * dy) / dlen);
        dot = (vx - b_vx) * dx + (vy - b_vy) * dy;
        vn = dot / dlen;
        nx = (vn * dx) / dlen;
        ny = (vn * dy) / dlen;
        wp = m_bmass; wb = m_pmass; tot = wp + wb;
        if (tot == 0) begin
          wp = 1; wb = 1; tot = 2;
        end
        vx = clamp_word(vx - (nx * 2 * wp) / tot);
        vy = clamp_word(vy - (ny * 2 * wp) / tot);
        b_vx = clamp_word(b_vx + (nx * 2 * wb) / tot);
        b_vy = clamp_word(b_vy + (ny * 2 * wb) / tot);
      end
    end
    r.px = word_t'(px); r.py = word_t'(py); r.vx = word_t'(vx); r.vy = word_t'(vy);
    r.hw = hw; r.hb = hb;
  endtask

  always @(posedge clk) begin
    state_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $error("unexpected result word");
        fails++;
      end else begin
        e = pending.pop_front();
        if (out_pos_x !== e.px) begin
          $error("out_pos_x exp %0d got %0d", e.px, out_pos_x); fails++;
        end
        if (out_pos_y !== e.py) begin
          $error("out_pos_y exp %0d got %0d", e.py, out_pos_y); fails++;
        end
        if (out_vel_x !== e.vx) begin
          $error("out_vel_x exp %0d got %0d", e.vx, out_vel_x); fails++;
        end
        if (out_vel_y !== e.vy) begin
          $error("out_vel_y exp %0d got %0d", e.vy, out_vel_y); fails++;
        end
        if (hit_wall !== e.hw) begin
          $error("hit_wall exp %0d got %0d", e.hw, hit_wall); fails++;
        end
        if (hit_ball !== e.hb) begin
          $error("hit_ball exp %0d got %0d", e.hb, hit_ball); fails++;
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int n;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      n = calm ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic wait_idle();
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [22:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HALF_BOX:    m_half  = val;
      REG_BALL_RADIUS: m_rad   = val;
      REG_TIME_STEP:   m_ts    = val & 23'h1FFFFF;
      REG_MASS_P:      m_pmass = val & 23'hFFFF;
      REG_MASS_B:      m_bmass = val & 23'hFFFF;
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic send(input stim_t s, input bit typed, input state_word_t t, input bit last);
    int gap;
    state_word_t e;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= s.kind;
    in_pos_x <= s.px;
    in_pos_y <= s.py;
    in_vel_x <= s.vx;
    in_vel_y <= s.vy;
    do @(posedge clk); while (!in_ready);
    step_collision(s, e);
    pending = {pending, (typed ? t : e)};
    if (last) in_valid <= 1'b0;
  endtask

  function automatic word_t rnd_word();
    return word_t'($urandom);
  endfunction

  function automatic stim_t rnd_stim();
    stim_t s;
    int sel;
    longint span;
    sel = $urandom_range(0, 9);
    s.kind = (sel >= 2);
    s.px = rnd_word(); s.py = rnd_word(); s.vx = rnd_word(); s.vy = rnd_word();
    if (sel >= 2 && sel <= 7) begin
      // aim near the ball so that most words collide
      span = m_rad + 2;
      s.px = word_t'(clamp_word(b_px + $signed($urandom_range(0, 2 * span)) - span));
      s.py = word_t'(clamp_word(b_py + $signed($urandom_range(0, 2 * span)) - span));
      s.vx = word_t'($signed($urandom_range(0, 4194304)) - 2097152);
      s.vy = word_t'($signed($urandom_range(0, 4194304)) - 2097152);
      if (sel == 7) begin
        s.vx = rnd_word(); s.vy = rnd_word();
      end
    end
    return s;
  endfunction

  row_t rows[$];

  function automatic row_t mk(logic k, longint px, longint py, longint vx, longint vy);
    row_t r;
    r.st.kind = k;
    r.st.px = word_t'(px); r.st.py = word_t'(py);
    r.st.vx = word_t'(vx); r.st.vy = word_t'(vy);
    r.typed = 1'b0;
    r.res = '{default: '0};
    return r;
  endfunction

  initial begin
    row_t r;
    state_word_t none;
    logic [22:0] cfgs[7][5];
    none = '{default: '0};
    rst <= 1'b1;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_valid <= 1'b0; kind <= 1'b0;
    in_pos_x <= '0; in_pos_y <= '0; in_vel_x <= '0; in_vel_y <= '0;
    m_half = 786432; m_rad = 314573; m_ts = 10486; m_pmass = 256; m_bmass = 2560;
    b_px = 0; b_py = 0; b_vx = 0; b_vy = 0;

    // ball at rest: tick, particle on centre (no hit), particle on the rim (hit)
    r = mk(0, 0, 0, 0, 0); r.typed = 1; rows = {rows, r};
    r = mk(1, 0, 0, 0, 0); r.typed = 1; rows = {rows, r};
    r = mk(1, 314573, 0, 0, 0); r.typed = 1;
    r.res = '{px: 314573, py: 0, vx: 0, vy: 0, hw: 0, hb: 1}; rows = {rows, r};
    rows = {rows, mk(1, WMAXL, WMAXL, WMAXL, WMAXL)};
    rows = {rows, mk(1, WMINL, WMINL, WMINL, WMINL)};
    rows = {rows, mk(1, WMAXL, WMINL, 0, 0)};
    rows = {rows, mk(1, 100000, 50000, -2000000, 300000)};
    rows = {rows, mk(0, 0, 0, 0, 0)};
    rows = {rows, mk(1, 314573, 0, -1048576, 0)};
    rows = {rows, mk(1, -200000, -100000, WMAXL, WMINL)};
    rows = {rows, mk(1, -786432, 786432, 0, 0)};
    rows = {rows, mk(1, 1, 1, -1, -1)};
    rows = {rows, mk(0, 0, 0, 0, 0)};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].st, rows[i].typed, rows[i].res, i == rows.size() - 1);

    cfgs[0] = '{786432, 314573, 10486, 256, 2560};
    cfgs[1] = '{23'd0, 23'd0, 23'd0, 23'd1, 23'd1};
    cfgs[2] = '{23'd4194304, 23'd4194304, 23'd1048576, 23'd65535, 23'd65535};
    cfgs[3] = '{23'd2097152, 23'd1048576, 23'd200000, 23'd65535, 23'd1};
    cfgs[4] = '{23'd1500000, 23'd600000, 23'd50000, 23'h7F0000, 23'h7F0000};
    cfgs[5] = '{23'h7FFFFF, 23'd800000, 23'h1FFFFF, 23'd1, 23'd65535};
    cfgs[6] = '{23'd1000000, 23'd300000, 23'd30000, 23'h55AA, 23'h2A55};

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      for (int i = 0; i < 5; i++) cfg_write(3'(i), cfgs[ph][i], 1'b0);
      cfg_write(3'd5 + 3'(ph % 3), 23'h7FFFFF, 1'b1);
      for (int n = 0; n < 120; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        send(rnd_stim(), 1'b0, none, n == 119);
      end
    end

    calm = 1'b0;
    wait_idle();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
src/pbc_pkg.sv
src/pbc_divsqrt.sv
src/particle_ball_box_collision_step.sv
tb/sv/tb_top.sv
